/* hdl/mfvl_pkg.sv */
// Package for the muon follower veto live-time block.
// Holds field widths, flag bit positions, register indexes, reset values and
// the configuration and result word types. No dependencies.
package mfvl_pkg;

  // Field widths fixed by the event and result formats
  localparam int FLAG_W   = 64;
  localparam int HITS_W   = 16;
  localparam int WINDOW_W = 48;
  localparam int TICK_W   = 8;
  localparam int SUM_W    = 64;
  localparam int COUNT_W  = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = WINDOW_W;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WINDOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TICK      = 2'd2;

  // Register reset values
  localparam logic [HITS_W-1:0]   THRESHOLD_RST = 16'd3000;
  localparam logic [WINDOW_W-1:0] WINDOW_RST    = 48'd20000000000;
  localparam logic [TICK_W-1:0]   TICK_RST      = 8'd20;

  // Data cleaning flag bits (set means "not a muon" / "not a follower")
  localparam int FLAG_NOT_MUON_BIT     = 7;
  localparam int FLAG_NOT_FOLLOWER_BIT = 14;

  // Elapsed-time product: stamp (at most 64 bits) times tick
  localparam int PROD_W = SUM_W + TICK_W;

  typedef struct packed {
    logic [HITS_W-1:0]   muon_hit_threshold;
    logic [WINDOW_W-1:0] veto_window_ns;
    logic [TICK_W-1:0]   tick_ns;
  } cfg_t;

  typedef struct packed {
    logic               accept;
    logic [SUM_W-1:0]   follower_dead_ns;
    logic [SUM_W-1:0]   pileup_dead_ns;
    logic [COUNT_W-1:0] veto_total;
  } res_t;

endpackage

/* hdl/mfvl_if.sv */
// Valid/ready channel interfaces for event words and result words.
// Depends on mfvl_pkg for field widths.
interface mfvl_in_if #(parameter int STAMP_BITS = 43);
  import mfvl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [STAMP_BITS-1:0] clock_count;
  logic [FLAG_W-1:0]     dc_flag_word;
  logic [HITS_W-1:0]     nhits_cleaned;

  modport source (output valid, clock_count, dc_flag_word, nhits_cleaned, input ready);
  modport sink   (input valid, clock_count, dc_flag_word, nhits_cleaned, output ready);
endinterface

interface mfvl_out_if;
  import mfvl_pkg::*;
  logic               valid;
  logic               ready;
  logic               accept;
  logic [SUM_W-1:0]   follower_dead_ns;
  logic [SUM_W-1:0]   pileup_dead_ns;
  logic [COUNT_W-1:0] veto_total;

  modport source (output valid, accept, follower_dead_ns, pileup_dead_ns, veto_total,
                  input ready);
  modport sink   (input valid, accept, follower_dead_ns, pileup_dead_ns, veto_total,
                  output ready);
endinterface

/* hdl/mfvl_elapsed.sv */
// Elapsed time in ns between two wrapping stamps, saturated to 64 bits.
// Depends on mfvl_pkg for widths.
module mfvl_elapsed #(
  parameter int STAMP_BITS = 43
) (
  input  logic [STAMP_BITS-1:0]     now,
  input  logic [STAMP_BITS-1:0]     start,
  input  logic [mfvl_pkg::TICK_W-1:0] tick_ns,
  output logic [mfvl_pkg::SUM_W-1:0]  elapsed_ns
);
  import mfvl_pkg::*;

  logic [STAMP_BITS-1:0] ticks;
  logic [PROD_W-1:0]     prod;

  // Tick difference wraps at the stamp width
  assign ticks = now - start;

  // 64 x 8 product, clipped when it leaves 64 bits
  assign prod = PROD_W'(ticks) * PROD_W'(tick_ns);
  assign elapsed_ns = (|prod[PROD_W-1:SUM_W]) ? {SUM_W{1'b1}} : prod[SUM_W-1:0];

endmodule

/* hdl/mfvl_core.sv */
// Veto and follower state with the per-event decision logic.
// Depends on mfvl_pkg and mfvl_elapsed.
module mfvl_core #(
  parameter int STAMP_BITS = 43
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic [STAMP_BITS-1:0]       now,
  input  logic [mfvl_pkg::FLAG_W-1:0] flags,
  input  logic [mfvl_pkg::HITS_W-1:0] hits,
  input  mfvl_pkg::cfg_t              cfg,
  output mfvl_pkg::res_t              res
);
  import mfvl_pkg::*;

  logic                  fol_active_r, fol_active_nxt;
  logic                  veto_active_r, veto_active_nxt;
  logic [STAMP_BITS-1:0] fol_start_r, fol_start_nxt;
  logic [STAMP_BITS-1:0] veto_start_r, veto_start_nxt;
  logic [SUM_W-1:0]      fol_sum_r, fol_sum_nxt;
  logic [SUM_W-1:0]      pile_sum_r, pile_sum_nxt;
  logic [COUNT_W-1:0]    veto_cnt_r, veto_cnt_nxt;

  logic [SUM_W-1:0] fol_el;
  logic [SUM_W-1:0] veto_el;
  logic [SUM_W:0]   fol_add;
  logic [SUM_W:0]   pile_add;
  logic [SUM_W-1:0] fol_sum_sat;
  logic [SUM_W-1:0] pile_sum_sat;
  logic             muon;
  logic             in_window;
  logic             accept;

  mfvl_elapsed #(.STAMP_BITS(STAMP_BITS)) u_fol_el (
    .now(now), .start(fol_start_r), .tick_ns(cfg.tick_ns), .elapsed_ns(fol_el)
  );

  mfvl_elapsed #(.STAMP_BITS(STAMP_BITS)) u_veto_el (
    .now(now), .start(veto_start_r), .tick_ns(cfg.tick_ns), .elapsed_ns(veto_el)
  );

  // Saturating running sums
  assign fol_add      = {1'b0, fol_sum_r} + {1'b0, fol_el};
  assign pile_add     = {1'b0, pile_sum_r} + {1'b0, veto_el};
  assign fol_sum_sat  = fol_add[SUM_W] ? {SUM_W{1'b1}} : fol_add[SUM_W-1:0];
  assign pile_sum_sat = pile_add[SUM_W] ? {SUM_W{1'b1}} : pile_add[SUM_W-1:0];

  assign muon      = !flags[FLAG_NOT_MUON_BIT] && (hits > cfg.muon_hit_threshold);
  assign in_window = veto_active_r && (veto_el < SUM_W'(cfg.veto_window_ns));

  // Decision and next state
  always_comb begin
    fol_active_nxt  = fol_active_r;
    veto_active_nxt = veto_active_r;
    fol_start_nxt   = fol_start_r;
    veto_start_nxt  = veto_start_r;
    fol_sum_nxt     = fol_sum_r;
    pile_sum_nxt    = pile_sum_r;
    veto_cnt_nxt    = veto_cnt_r;
    accept          = 1'b0;
    priority if (muon) begin
      // muon closes any follower window, opens or extends the veto
      if (fol_active_r) begin
        fol_sum_nxt    = fol_sum_sat;
        fol_active_nxt = 1'b0;
      end
      if (!veto_active_r) begin
        if (veto_cnt_r != {COUNT_W{1'b1}}) begin
          veto_cnt_nxt = veto_cnt_r + COUNT_W'(1);
        end
        veto_active_nxt = 1'b1;
      end else begin
        pile_sum_nxt = pile_sum_sat;
      end
      veto_start_nxt = now;
    end else if (in_window) begin
      // vetoed, nothing changes
    end else begin
      veto_active_nxt = 1'b0;
      if (!flags[FLAG_NOT_FOLLOWER_BIT]) begin
        if (fol_active_r) begin
          fol_sum_nxt = fol_sum_sat;
        end
        fol_active_nxt = 1'b1;
        fol_start_nxt  = now;
      end else begin
        fol_active_nxt = 1'b0;
        accept         = 1'b1;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fol_active_r  <= 1'b0;
      veto_active_r <= 1'b0;
      fol_start_r   <= '0;
      veto_start_r  <= '0;
      fol_sum_r     <= '0;
      pile_sum_r    <= '0;
      veto_cnt_r    <= '0;
    end else if (en) begin
      fol_active_r  <= fol_active_nxt;
      veto_active_r <= veto_active_nxt;
      fol_start_r   <= fol_start_nxt;
      veto_start_r  <= veto_start_nxt;
      fol_sum_r     <= fol_sum_nxt;
      pile_sum_r    <= pile_sum_nxt;
      veto_cnt_r    <= veto_cnt_nxt;
    end
  end

  // Result word carries the state after this event
  assign res.accept           = accept;
  assign res.follower_dead_ns = fol_sum_nxt;
  assign res.pileup_dead_ns   = pile_sum_nxt;
  assign res.veto_total       = veto_cnt_nxt;

endmodule

/* hdl/muon_follower_veto_livetime.sv */
// Channel     | dir | word
// in_ch       | in  | clock_count, dc_flag_word, nhits_cleaned (valid/ready)
// out_ch      | out | accept, follower_dead_ns, pileup_dead_ns, veto_total (valid/ready)
// cfg_*       | in  | cfg_we, cfg_idx, cfg_data (write only)
//
// One event word per cycle sustained while out_ch is not stalled; an accepted word goes
// through the input register, then the decision logic into the result register.
// The decision path is one stamp subtract, a 64x8 multiply and a 64-bit add/compare.
// Synchronous active-low reset clears windows, totals, valid bits; sets cfg defaults.
// A stalled output holds its word; the input register stalls behind it.
// Top level: muon veto, pileup and lone-follower live-time block.
// Depends on mfvl_pkg, mfvl_if, mfvl_elapsed and mfvl_core.
module muon_follower_veto_livetime #(
  parameter int STAMP_BITS = 43
) (
  input  logic                              clk,
  input  logic                              rst_n,
  mfvl_in_if.sink                           in_ch,
  mfvl_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [mfvl_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [mfvl_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mfvl_pkg::*;

  cfg_t cfg_r;

  logic                  s1_valid_r;
  logic [STAMP_BITS-1:0] s1_now_r;
  logic [FLAG_W-1:0]     s1_flags_r;
  logic [HITS_W-1:0]     s1_hits_r;

  logic  out_valid_r;
  res_t  out_res_r;
  res_t  core_res;

  logic in_ready;
  logic in_load;
  logic adv;
  logic core_en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.muon_hit_threshold <= THRESHOLD_RST;
      cfg_r.veto_window_ns     <= WINDOW_RST;
      cfg_r.tick_ns            <= TICK_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_IDX_THRESHOLD: cfg_r.muon_hit_threshold <= cfg_data[HITS_W-1:0];
        CFG_IDX_WINDOW:    cfg_r.veto_window_ns     <= cfg_data[WINDOW_W-1:0];
        CFG_IDX_TICK:      cfg_r.tick_ns            <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake
  assign adv      = !out_valid_r || out_ch.ready;
  assign in_ready = !s1_valid_r || adv;
  assign in_load  = in_ch.valid && in_ready;
  assign core_en  = s1_valid_r && adv;

  assign in_ch.ready = in_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      s1_now_r   <= in_ch.clock_count;
      s1_flags_r <= in_ch.dc_flag_word;
      s1_hits_r  <= in_ch.nhits_cleaned;
    end
  end

  mfvl_core #(.STAMP_BITS(STAMP_BITS)) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (core_en),
    .now   (s1_now_r),
    .flags (s1_flags_r),
    .hits  (s1_hits_r),
    .cfg   (cfg_r),
    .res   (core_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (core_en) begin
      out_res_r <= core_res;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.accept           = out_res_r.accept;
  assign out_ch.follower_dead_ns = out_res_r.follower_dead_ns;
  assign out_ch.pileup_dead_ns   = out_res_r.pileup_dead_ns;
  assign out_ch.veto_total       = out_res_r.veto_total;

`ifndef SYNTH
  // An empty input register always takes a word
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input register empty but not ready");

  // A held event word is not dropped while the result side stalls
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_now_r) && $stable(s1_hits_r))
    else $error("pending event lost during output stall");

  // The veto count in a new result never goes below the one before it
  a_veto_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    core_en && out_valid_r && out_ch.ready |=> out_res_r.veto_total >= $past(out_res_r.veto_total))
    else $error("veto total decreased");
`endif

endmodule
